FILE: rtl/iterative_matrix_inverse_4x4_macros.svh
// Assertion helpers used by the RTL controller (imi_ctrl).
`ifndef ITERATIVE_MATRIX_INVERSE_4X4_MACROS_SVH
`define ITERATIVE_MATRIX_INVERSE_4X4_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IMI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define IMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/imi_pkg.sv
package imi_pkg;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_ZERO = 2'd1;
    localparam t_status ST_SAT  = 2'd2;

    localparam logic [7:0] MAX_ITER_RESET = 8'd10;

    // controller to datapath commands
    typedef struct packed {
        logic src_we;
        logic norm_clr;
        logic norm_acc;
        logic norm_first;
        logic norm_last;
        logic norm_col;
        logic div_start;
        logic div_sel;
        logic est_we;
        logic mac_en;
        logic mac_first;
        logic mac_last;
        logic mac_phase2;
        logic mac_diag;
        logic nz_clr;
        logic out_load;
        logic out_last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic zero_norm;
        logic div_done;
        logic mac_busy;
        logic nz;
    } t_dp_stat;

endpackage

FILE: rtl/imi_ram.sv
module imi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/imi_div.sv
module imi_div #(
    parameter int DVD_W = 64,
    parameter int DSR_W = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DVD_W-1:0] r_quo;
    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   diff;

    // restoring step: one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!diff[DSR_W]) begin
                r_rem <= diff[DSR_W-1:0];
            end else begin
                r_rem <= shifted[DSR_W-1:0];
            end
            r_quo <= {r_quo[DVD_W-2:0], ~diff[DSR_W]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/imi_dp.sv
module imi_dp
    import imi_pkg::*;
#(
    parameter int MATRIX_DIM = 4,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_dp_cmd                               i_cmd,
    output t_dp_stat                              o_stat,
    input  logic signed [31:0]                    i_element,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_src_addr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM):0]   i_est_raddr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_ipe_raddr,
    input  logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] i_dst_idx,
    input  logic                                  i_bank,
    output logic signed [31:0]                    o_inverse_element,
    output logic                                  o_last_of_matrix,
    output t_status                               o_status
);

    localparam int N      = MATRIX_DIM * MATRIX_DIM;
    localparam int AW     = $clog2(N);
    localparam int NORM_W = 32 + $clog2(N);
    localparam int DVD_W  = 32 + 2 * FRAC_BITS;
    localparam int ACC_W  = 64 + $clog2(MATRIX_DIM);

    localparam logic signed [ACC_W-1:0] HALF_A =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] MAX_A = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN_A = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [33:0] ONE34 =
        {{(33-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DVD_W-1:0] LIM_P = {{(DVD_W-31){1'b0}}, {31{1'b1}}};
    localparam logic [DVD_W-1:0] LIM_N = {{(DVD_W-32){1'b0}}, 1'b1, {31{1'b0}}};

    // saturate a 34-bit value to 32 bits, flag in the top bit
    function automatic logic [32:0] f_sat34(input logic signed [33:0] v);
        logic [32:0] res;
        if (v > 34'sh07FFFFFFF) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (v < 34'sh380000000) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    logic [31:0]             src_rd;
    logic [31:0]             est_rd;
    logic [31:0]             ipe_rd;
    logic [31:0]             src_abs;
    logic                    est_we;
    logic [AW:0]             est_waddr;
    logic [31:0]             est_wdata;
    logic                    ipe_we;

    // norm pass
    logic                    r_n_v;
    logic                    r_n_first;
    logic                    r_n_last;
    logic                    r_n_col;
    logic [NORM_W-1:0]       r_nacc;
    logic [NORM_W-1:0]       r_nrow;
    logic [NORM_W-1:0]       r_ncol;
    logic [NORM_W-1:0]       nsum;

    // scaling divide
    logic                    div_done;
    logic [DVD_W-1:0]        div_q;
    logic [DVD_W-1:0]        div_dvd;
    logic [NORM_W-1:0]       div_dsr;
    logic                    r_neg;
    logic                    scale_sat;
    logic [31:0]             scale_val;

    // multiply-accumulate pipeline
    logic                    r_s1_v;
    logic                    r_s1_first;
    logic                    r_s1_last;
    logic                    r_s1_ph2;
    logic                    r_s1_diag;
    logic [AW-1:0]           r_s1_dest;
    logic signed [31:0]      mx;
    logic signed [31:0]      my;
    logic                    r_s2_v;
    logic                    r_s2_first;
    logic                    r_s2_last;
    logic                    r_s2_ph2;
    logic                    r_s2_diag;
    logic [AW-1:0]           r_s2_dest;
    logic signed [63:0]      r_s2_p;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] msum;
    logic                    r_s3_v;
    logic                    r_s3_ph2;
    logic                    r_s3_diag;
    logic [AW-1:0]           r_s3_dest;
    logic signed [ACC_W-1:0] r_s3_sum;
    logic signed [ACC_W-1:0] rnd;
    logic [31:0]             rnd_val;
    logic                    rnd_sat;
    logic signed [33:0]      id34;
    logic [32:0]             e_res;
    logic [32:0]             ipe_res;

    logic                    r_sat;
    logic                    r_nz;

    // matrix stores
    imi_ram #(.WIDTH(32), .DEPTH(N)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.src_we),
        .i_waddr (i_src_addr),
        .i_wdata (i_element),
        .i_raddr (i_src_addr),
        .o_rdata (src_rd)
    );

    imi_ram #(.WIDTH(32), .DEPTH(2 * N)) u_est_ram (
        .i_clk   (i_clk),
        .i_we    (est_we),
        .i_waddr (est_waddr),
        .i_wdata (est_wdata),
        .i_raddr (i_est_raddr),
        .o_rdata (est_rd)
    );

    imi_ram #(.WIDTH(32), .DEPTH(N)) u_ipe_ram (
        .i_clk   (i_clk),
        .i_we    (ipe_we),
        .i_waddr (r_s3_dest),
        .i_wdata (ipe_res[31:0]),
        .i_raddr (i_ipe_raddr),
        .o_rdata (ipe_rd)
    );

    // absolute value and row/column sums
    always_comb begin
        src_abs = src_rd[31] ? (~src_rd + 32'd1) : src_rd;
        nsum    = (r_n_first ? '0 : r_nacc) + NORM_W'(src_abs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else begin
            r_n_v <= i_cmd.norm_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n_first <= i_cmd.norm_first;
        r_n_last  <= i_cmd.norm_last;
        r_n_col   <= i_cmd.norm_col;
        if (i_cmd.norm_clr) begin
            r_nrow <= '0;
            r_ncol <= '0;
        end else if (r_n_v) begin
            r_nacc <= nsum;
            if (r_n_last && r_n_col && (nsum > r_ncol)) begin
                r_ncol <= nsum;
            end
            if (r_n_last && !r_n_col && (nsum > r_nrow)) begin
                r_nrow <= nsum;
            end
        end
    end

    // divide |a|<<F by row norm, then the quotient<<F by column norm
    always_comb begin
        if (i_cmd.div_sel) begin
            div_dvd = {div_q[DVD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            div_dsr = r_ncol;
        end else begin
            div_dvd = DVD_W'({src_abs, {FRAC_BITS{1'b0}}});
            div_dsr = r_nrow;
        end
    end

    imi_div #(.DVD_W(DVD_W), .DSR_W(NORM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start && !i_cmd.div_sel) begin
            r_neg <= src_rd[31];
        end
    end

    // signed, saturated scaled element
    always_comb begin
        if (r_neg) begin
            scale_sat = div_q > LIM_N;
            scale_val = scale_sat ? 32'h8000_0000 : (~div_q[31:0] + 32'd1);
        end else begin
            scale_sat = div_q > LIM_P;
            scale_val = scale_sat ? 32'h7FFF_FFFF : div_q[31:0];
        end
    end

    // MAC stage 1: operands from the stores, one product
    always_comb begin
        mx = r_s1_ph2 ? $signed(ipe_rd) : $signed(est_rd);
        my = r_s1_ph2 ? $signed(est_rd) : $signed(src_rd);
    end

    // MAC stage 2: accumulate
    always_comb begin
        msum = (r_s2_first ? '0 : r_acc) + ACC_W'(r_s2_p);
    end

    // MAC stage 3: round, saturate, residual and I+E
    always_comb begin
        rnd = (r_s3_sum + HALF_A) >>> FRAC_BITS;
        if (rnd > MAX_A) begin
            rnd_val = 32'h7FFF_FFFF;
            rnd_sat = 1'b1;
        end else if (rnd < MIN_A) begin
            rnd_val = 32'h8000_0000;
            rnd_sat = 1'b1;
        end else begin
            rnd_val = rnd[31:0];
            rnd_sat = 1'b0;
        end
        id34    = r_s3_diag ? ONE34 : '0;
        e_res   = f_sat34(id34 - {{2{rnd_val[31]}}, rnd_val});
        ipe_res = f_sat34(id34 + {{2{e_res[31]}}, e_res[31:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.mac_en;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.mac_first;
        r_s1_last  <= i_cmd.mac_last;
        r_s1_ph2   <= i_cmd.mac_phase2;
        r_s1_diag  <= i_cmd.mac_diag;
        r_s1_dest  <= i_dst_idx;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_ph2   <= r_s1_ph2;
        r_s2_diag  <= r_s1_diag;
        r_s2_dest  <= r_s1_dest;
        r_s2_p     <= mx * my;
        if (r_s2_v) begin
            r_acc <= msum;
        end
        if (r_s2_v && r_s2_last) begin
            r_s3_sum  <= msum;
            r_s3_ph2  <= r_s2_ph2;
            r_s3_diag <= r_s2_diag;
            r_s3_dest <= r_s2_dest;
        end
    end

    // store writes
    always_comb begin
        est_we = i_cmd.est_we || (r_s3_v && r_s3_ph2);
        ipe_we = r_s3_v && !r_s3_ph2;
        if (i_cmd.est_we) begin
            est_waddr = {i_bank, i_dst_idx};
            est_wdata = scale_val;
        end else begin
            est_waddr = {~i_bank, r_s3_dest};
            est_wdata = rnd_val;
        end
    end

    // sticky saturation and nonzero-residual flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
            r_nz  <= 1'b0;
        end else begin
            if (i_cmd.norm_clr) begin
                r_sat <= 1'b0;
            end else if (i_cmd.est_we && scale_sat) begin
                r_sat <= 1'b1;
            end else if (r_s3_v) begin
                if (rnd_sat || (!r_s3_ph2 && (e_res[32] || ipe_res[32]))) begin
                    r_sat <= 1'b1;
                end
            end
            if (i_cmd.nz_clr) begin
                r_nz <= 1'b0;
            end else if (ipe_we && (e_res[31:0] != 32'd0)) begin
                r_nz <= 1'b1;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_inverse_element <= o_stat.zero_norm ? 32'sd0 : $signed(est_rd);
            o_last_of_matrix  <= i_cmd.out_last;
            if (o_stat.zero_norm) begin
                o_status <= ST_ZERO;
            end else if (r_sat) begin
                o_status <= ST_SAT;
            end else begin
                o_status <= ST_OK;
            end
        end
    end

    always_comb begin
        o_stat.zero_norm = (r_nrow == '0) || (r_ncol == '0);
        o_stat.div_done  = div_done;
        o_stat.mac_busy  = r_s1_v || r_s2_v || r_s3_v;
        o_stat.nz        = r_nz;
    end

endmodule

FILE: rtl/imi_ctrl.sv
`include "iterative_matrix_inverse_4x4_macros.svh"

module imi_ctrl
    import imi_pkg::*;
#(
    parameter int MATRIX_DIM = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    input  logic                                     i_cfg_we,
    input  logic [7:0]                               i_cfg_data,
    output t_dp_cmd                                  o_cmd,
    input  t_dp_stat                                 i_stat,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_src_addr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM):0]   o_est_raddr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_ipe_raddr,
    output logic [$clog2(MATRIX_DIM*MATRIX_DIM)-1:0] o_dst_idx,
    output logic                                     o_bank
);

    localparam int N  = MATRIX_DIM * MATRIX_DIM;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(MATRIX_DIM);
    localparam logic [CW-1:0] DLAST = CW'(MATRIX_DIM - 1);
    localparam logic [AW-1:0] NLAST = AW'(N - 1);

    typedef enum logic [15:0] {
        S_LOAD  = 16'h0001,
        S_NROW  = 16'h0002,
        S_NCOL  = 16'h0004,
        S_NWT   = 16'h0008,
        S_NCHK  = 16'h0010,
        S_SRD   = 16'h0020,
        S_SDV1  = 16'h0040,
        S_SWT1  = 16'h0080,
        S_SDV2  = 16'h0100,
        S_SWT2  = 16'h0200,
        S_ITCHK = 16'h0400,
        S_MUL1  = 16'h0800,
        S_DRN1  = 16'h1000,
        S_MUL2  = 16'h2000,
        S_DRN2  = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    // row-major index of (row, col)
    function automatic logic [AW-1:0] f_idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * AW'(MATRIX_DIM) + AW'(c);
    endfunction

    t_state        r_state, n_state;
    logic [AW-1:0] r_ld, n_ld;
    logic [AW-1:0] r_oidx, n_oidx;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [7:0]    r_it, n_it;
    logic [7:0]    r_maxit;
    logic          r_bank, n_bank;
    logic          r_pend, n_pend;
    logic          r_ovalid, n_ovalid;
    logic          li, lj, lk;

    always_comb begin
        li = r_i == DLAST;
        lj = r_j == DLAST;
        lk = r_k == DLAST;
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_ld     = r_ld;
        n_oidx   = r_oidx;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_it     = r_it;
        n_bank   = r_bank;
        n_pend   = r_pend;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_cmd.src_we = 1'b1;
                    if (r_ld == NLAST) begin
                        n_ld           = '0;
                        o_cmd.norm_clr = 1'b1;
                        n_it           = '0;
                        n_i            = '0;
                        n_j            = '0;
                        n_state        = S_NROW;
                    end else begin
                        n_ld = r_ld + 1'b1;
                    end
                end
            end
            S_NROW, S_NCOL: begin
                o_cmd.norm_acc   = 1'b1;
                o_cmd.norm_first = r_j == '0;
                o_cmd.norm_last  = lj;
                o_cmd.norm_col   = r_state == S_NCOL;
                n_j = lj ? '0 : r_j + 1'b1;
                if (lj) begin
                    n_i = li ? '0 : r_i + 1'b1;
                end
                if (li && lj) begin
                    n_state = (r_state == S_NROW) ? S_NCOL : S_NWT;
                end
            end
            S_NWT: begin
                n_state = S_NCHK;
            end
            S_NCHK: begin
                n_i = '0;
                n_j = '0;
                if (i_stat.zero_norm) begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SDV1;
            end
            S_SDV1: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_SWT1;
            end
            S_SWT1: begin
                if (i_stat.div_done) begin
                    n_state = S_SDV2;
                end
            end
            S_SDV2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = S_SWT2;
            end
            S_SWT2: begin
                if (i_stat.div_done) begin
                    o_cmd.est_we = 1'b1;
                    n_j = lj ? '0 : r_j + 1'b1;
                    if (lj) begin
                        n_i = li ? '0 : r_i + 1'b1;
                    end
                    n_state = (li && lj) ? S_ITCHK : S_SRD;
                end
            end
            S_ITCHK: begin
                if (r_it == r_maxit) begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.nz_clr = 1'b1;
                    n_i          = '0;
                    n_j          = '0;
                    n_k          = '0;
                    n_state      = S_MUL1;
                end
            end
            S_MUL1, S_MUL2: begin
                o_cmd.mac_en     = 1'b1;
                o_cmd.mac_first  = r_k == '0;
                o_cmd.mac_last   = lk;
                o_cmd.mac_phase2 = r_state == S_MUL2;
                o_cmd.mac_diag   = r_i == r_j;
                n_k = lk ? '0 : r_k + 1'b1;
                if (lk) begin
                    n_j = lj ? '0 : r_j + 1'b1;
                end
                if (lk && lj) begin
                    n_i = li ? '0 : r_i + 1'b1;
                end
                if (li && lj && lk) begin
                    n_state = (r_state == S_MUL1) ? S_DRN1 : S_DRN2;
                end
            end
            S_DRN1: begin
                if (!i_stat.mac_busy) begin
                    n_state = S_MUL2;
                end
            end
            S_DRN2: begin
                if (!i_stat.mac_busy) begin
                    n_bank = ~r_bank;
                    n_it   = r_it + 1'b1;
                    n_oidx = '0;
                    n_state = i_stat.nz ? S_ITCHK : S_OUT;
                end
            end
            S_OUT: begin
                if (r_pend) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = r_oidx == NLAST;
                    n_pend         = 1'b0;
                    n_ovalid       = 1'b1;
                    if (r_oidx == NLAST) begin
                        n_oidx  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_oidx = r_oidx + 1'b1;
                    end
                end else if (!r_ovalid) begin
                    n_pend = 1'b1;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // store addresses
    always_comb begin
        o_src_addr  = '0;
        o_est_raddr = {r_bank, r_oidx};
        o_ipe_raddr = f_idx(r_i, r_k);
        o_dst_idx   = f_idx(r_i, r_j);
        case (r_state)
            S_LOAD:               o_src_addr = r_ld;
            S_NROW:               o_src_addr = f_idx(r_i, r_j);
            S_NCOL, S_SRD, S_SDV1: o_src_addr = f_idx(r_j, r_i);
            S_MUL1: begin
                o_src_addr  = f_idx(r_k, r_j);
                o_est_raddr = {r_bank, f_idx(r_i, r_k)};
            end
            S_MUL2:               o_est_raddr = {r_bank, f_idx(r_k, r_j)};
            default:              o_src_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ld     <= '0;
            r_oidx   <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_it     <= '0;
            r_maxit  <= MAX_ITER_RESET;
            r_bank   <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ld     <= n_ld;
            r_oidx   <= n_oidx;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_it     <= n_it;
            r_bank   <= n_bank;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_maxit <= i_cfg_data;
            end
        end
    end

    assign o_stall = r_state != S_LOAD;
    assign o_valid = r_ovalid;
    assign o_bank  = r_bank;

    // a result beat only appears while emitting
    `IMI_ASSERT_IMPL(a_out_rise, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state == S_OUT))
    // a pending read always lands in the output register
    `IMI_ASSERT_NEXT(a_pend_load, i_clk, i_rst_n, r_pend, r_ovalid)
    // leaving load means a full matrix was taken
    `IMI_ASSERT_IMPL(a_load_exit, i_clk, i_rst_n,
                     $past(r_state == S_LOAD) && (r_state != S_LOAD), r_ld == '0)
    // products are fully written back before the next iteration decision
    `IMI_ASSERT_IMPL(a_itchk_drained, i_clk, i_rst_n, r_state == S_ITCHK, !i_stat.mac_busy)

endmodule

FILE: rtl/iterative_matrix_inverse_4x4.sv
// Newton-Schulz inverse of a MATRIX_DIM x MATRIX_DIM signed fixed-point matrix
// (Q16.16 by default). Elements are taken one beat per cycle while o_stall is
// low, in row-major order; after the last one the block computes the norms,
// forms the scaled transpose through a restoring divider that yields one bit a
// cycle (two divides per element, each with a 32+2*FRAC_BITS-bit dividend, 64
// bits for Q16.16), then runs up to max_iterations refinements, each two matrix
// products on one shared 32x32 multiply-accumulate unit, each product issued
// and then drained through the MAC pipeline. The result streams out from the
// estimate memory one beat at a time, each held until taken with i_stall low.
// max_iterations resets to 10; status is 1 for an all-zero input (zeros out),
// 2 if any saturation occurred while that matrix was processed.

module iterative_matrix_inverse_4x4
    import imi_pkg::*;
#(
    parameter int MATRIX_DIM = 4,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_element,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_inverse_element,
    output logic               o_last_of_matrix,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data
);

    localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [AW-1:0] src_addr;
    logic [AW:0]   est_raddr;
    logic [AW-1:0] ipe_raddr;
    logic [AW-1:0] dst_idx;
    logic          bank;

    imi_ctrl #(.MATRIX_DIM(MATRIX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_stat      (stat),
        .o_src_addr  (src_addr),
        .o_est_raddr (est_raddr),
        .o_ipe_raddr (ipe_raddr),
        .o_dst_idx   (dst_idx),
        .o_bank      (bank)
    );

    imi_dp #(.MATRIX_DIM(MATRIX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_element         (i_element),
        .i_src_addr        (src_addr),
        .i_est_raddr       (est_raddr),
        .i_ipe_raddr       (ipe_raddr),
        .i_dst_idx         (dst_idx),
        .i_bank            (bank),
        .o_inverse_element (o_inverse_element),
        .o_last_of_matrix  (o_last_of_matrix),
        .o_status          (o_status)
    );

endmodule
